// ===== sv/assert_macros.svh =====
// Assertion macros shared by the indexed list unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock outside reset.
`define ILIR_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ILIR_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define ILIR_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ilir_pkg.sv =====
// Types and constants for the indexed list insert/remove unit.
package ilir_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 4;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_POP_BACK  = 3'd3,
    OP_POP_FRONT = 3'd4,
    OP_REMOVE_AT = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_LOAD,
    CM_FROM_LEFT,
    CM_FROM_RIGHT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    word_t      load_word;
  } cell_ctl_t;

endpackage

// ===== sv/ilir_cell.sv =====
// One list slot: holds a word, loads new data or takes a neighbor's word.
module ilir_cell (
  input  logic              clk,
  input  ilir_pkg::cell_ctl_t ctl,
  input  ilir_pkg::word_t   left_word,
  input  ilir_pkg::word_t   right_word,
  output ilir_pkg::word_t   word
);
  import ilir_pkg::*;

  word_t word_next;

  always_comb begin
    unique case (ctl.mode)
      CM_LOAD:       word_next = ctl.load_word;
      CM_FROM_LEFT:  word_next = left_word;
      CM_FROM_RIGHT: word_next = right_word;
      default:       word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== sv/indexed_list_insert_remove_unit.sv =====
// A request's result, marked by done, is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle; busy stays low, and the row of slot cells shifts as each request is accepted.
// Each request gives exactly one result, shown for one cycle; the receiver cannot stall.
// Reset (rst, synchronous) empties the list; slot contents are undefined until written.
module indexed_list_insert_remove_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ilir_pkg::OP_W-1:0]     op,
  input  logic [ilir_pkg::POS_W-1:0]    position,
  input  logic signed [ilir_pkg::WORD_W-1:0] data_in,
  output logic                          done,
  output logic [ilir_pkg::ST_W-1:0]     status,
  output logic signed [ilir_pkg::WORD_W-1:0] data_out,
  output logic [ilir_pkg::CNT_W-1:0]    count
);
  import ilir_pkg::*;

  `include "assert_macros.svh"

  word_t     words [CAPACITY];
  cell_ctl_t ctl   [CAPACITY];

  cnt_t    entry_count;
  cnt_t    entry_count_next;
  logic    accept;
  logic    full;
  logic    empty;
  logic    pos_ok;
  logic    ins;
  logic    rem;
  idx_t    at;
  status_t st;
  word_t   data_out_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (entry_count == CNT_W'(CAPACITY));
  assign empty  = (entry_count == '0);
  assign pos_ok = (CMP_W'(position) < CMP_W'(entry_count));
  assign count  = entry_count;

  always_comb begin
    ins = 1'b0;
    rem = 1'b0;
    at  = '0;
    st  = ST_OK;
    unique case (op)
      OP_APPEND: begin
        if (full) st = ST_FULL;
        else begin
          ins = 1'b1;
          at  = idx_t'(entry_count);
        end
      end
      OP_INS_FRONT: begin
        if (full) st = ST_FULL;
        else ins = 1'b1;
      end
      OP_INS_AT: begin
        if (full) st = ST_FULL;
        else if (!pos_ok) st = ST_BADPOS;
        else begin
          ins = 1'b1;
          at  = idx_t'(position);
        end
      end
      OP_POP_BACK: begin
        if (empty) st = ST_EMPTY;
        else begin
          rem = 1'b1;
          at  = idx_t'(entry_count - CNT_W'(1));
        end
      end
      OP_POP_FRONT: begin
        if (empty) st = ST_EMPTY;
        else rem = 1'b1;
      end
      OP_REMOVE_AT: begin
        if (empty) st = ST_EMPTY;
        else if (!pos_ok) st = ST_BADPOS;
        else begin
          rem = 1'b1;
          at  = idx_t'(position);
        end
      end
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].load_word = word_t'(data_in);
      if (accept && ins && (idx_t'(i) == at)) ctl[i].mode = CM_LOAD;
      else if (accept && ins && (idx_t'(i) > at)) ctl[i].mode = CM_FROM_LEFT;
      else if (accept && rem && (idx_t'(i) >= at)) ctl[i].mode = CM_FROM_RIGHT;
      else ctl[i].mode = CM_HOLD;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ilir_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[g]),
      .left_word  ((g == 0) ? word_t'(data_in) : words[(g == 0) ? 0 : g - 1]),
      .right_word ((g == CAPACITY - 1) ? words[g] : words[(g == CAPACITY - 1) ? g : g + 1]),
      .word       (words[g])
    );
  end

  assign data_out_next = rem ? words[at] : '0;

  always_comb begin
    entry_count_next = entry_count;
    if (accept && ins) entry_count_next = entry_count + CNT_W'(1);
    else if (accept && rem) entry_count_next = entry_count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      done        <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= st;
      data_out <= data_out_next;
    end
  end

  `ILIR_CHECK(a_count_range, count <= CNT_W'(CAPACITY), "list count above capacity")
  `ILIR_NEXT(a_done_follows, accept, done, "accepted request gave no result")
  `ILIR_IMPLY(a_data_ok_only, done && (data_out != '0), status == ST_OK,
    "removed word shown with error status")
  `ILIR_NEXT(a_reject_keeps, accept && (st != ST_OK), count == $past(count),
    "rejected request changed the count")

endmodule
